>>> hdl/ctc_pkg.sv
// Package for the capture timestamp converter: fixed-point constants,
// field widths and the payload structs passed between pipeline sections.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ctc_pkg;

    // Default width of the free-running capture counter
    localparam int CTC_COUNTER_BITS = 25;

    // Widths of the item fields
    localparam int CTC_WORD_BITS   = 32;
    localparam int CTC_SECS_BITS   = 32;
    localparam int CTC_SUB_BITS    = 27;
    localparam int CTC_NOW_BITS    = 25;
    localparam int CTC_US_BITS     = 32;

    // Ticks to microseconds: us = (ticks * TICK_MUL) >> TICK_SHIFT (about 0.853333)
    localparam int            CTC_TICK_SHIFT = 24;
    localparam logic [23:0]   CTC_TICK_MUL   = 24'd14316553;

    // Subsecond scale of the system clock
    localparam logic [6:0]               CTC_SUBSEC_PER_US = 7'd75;
    localparam logic [31:0]              CTC_US_PER_SEC    = 32'd1000000;
    localparam logic [CTC_SUB_BITS-1:0]  CTC_SUBSEC_PER_SEC = 27'd75000000;

    // Low microsecond bits that hold any offset below one second
    localparam int CTC_US_LOW_BITS = 20;

    // Divide by 75 as a reciprocal multiply: q = (x * DIV_MUL) >> DIV_SHIFT,
    // exact for every 27-bit x
    localparam int            CTC_DIV_SHIFT     = 34;
    localparam int            CTC_DIV_MUL_BITS  = 28;
    localparam logic [27:0]   CTC_DIV_MUL       = 28'd229064923;
    localparam int            CTC_DIV_PROD_BITS = CTC_SUB_BITS + CTC_DIV_MUL_BITS;
    localparam int            CTC_QUOT_BITS     = CTC_DIV_PROD_BITS - CTC_DIV_SHIFT;

    localparam logic [31:0]   CTC_ALL_ONES = 32'hFFFF_FFFF;

    // Snapshot of the system clock that travels with each capture item
    typedef struct packed {
        logic [CTC_SECS_BITS-1:0] secs;
        logic [CTC_SUB_BITS-1:0]  sub;
    } t_snap;

    // Scaled offset handed from the scaling section to the tail
    typedef struct packed {
        logic                    too_old;
        logic [CTC_SUB_BITS-1:0] subsec;
        t_snap                   snap;
    } t_scaled;

endpackage

`default_nettype wire

>>> hdl/ctc_if.sv
// Valid/ready channel interfaces for capture items in and event times out.
// Depends on ctc_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface ctc_in_if
    import ctc_pkg::*;
    ;
    logic                     valid;
    logic                     ready;
    logic                     mode;
    logic [CTC_SECS_BITS-1:0] clock_seconds;
    logic [CTC_SUB_BITS-1:0]  clock_subseconds;
    logic [CTC_NOW_BITS-1:0]  counter_now;
    logic [CTC_WORD_BITS-1:0] captured_word;

    modport source (
        output valid, mode, clock_seconds, clock_subseconds, counter_now, captured_word,
        input  ready
    );
    modport sink (
        input  valid, mode, clock_seconds, clock_subseconds, counter_now, captured_word,
        output ready
    );
endinterface

interface ctc_out_if
    import ctc_pkg::*;
    ;
    logic                     valid;
    logic                     ready;
    logic [CTC_SECS_BITS-1:0] event_seconds;
    logic [CTC_US_BITS-1:0]   event_microseconds;
    logic                     too_old;

    modport source (
        output valid, event_seconds, event_microseconds, too_old,
        input  ready
    );
    modport sink (
        input  valid, event_seconds, event_microseconds, too_old,
        output ready
    );
endinterface

`default_nettype wire

>>> hdl/ctc_front.sv
// Front section: holds the sync snapshot and computes the tick offset of
// each capture word. Depends on ctc_pkg and ctc_in_if.
`timescale 1ns / 1ps
`default_nettype none

module ctc_front
    import ctc_pkg::*;
#(
    parameter int COUNTER_BITS = CTC_COUNTER_BITS
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    ctc_in_if.sink                       i_item,
    output logic                         o_valid,
    input  wire logic                    i_ready,
    output logic [COUNTER_BITS-1:0]      o_offset,
    output t_snap                        o_snap
);

    logic [CTC_SECS_BITS-1:0] r_sync_secs;
    logic [CTC_SUB_BITS-1:0]  r_sync_sub;
    logic [COUNTER_BITS-1:0]  r_sync_cnt;

    logic                     r_valid;
    logic [COUNTER_BITS-1:0]  r_offset;
    t_snap                    r_snap;

    logic                     w_en;
    logic                     w_accept;
    logic [COUNTER_BITS-1:0]  w_cnt;
    logic [COUNTER_BITS-1:0]  n_sync_cnt;
    logic                     w_capture;

    // Advance when the stage is empty or its item moves on
    assign w_en         = !r_valid || i_ready;
    assign i_item.ready = w_en;
    assign w_accept     = i_item.valid && w_en;

    // Counter of the capture word sits in its top bits
    assign w_cnt      = i_item.captured_word[CTC_WORD_BITS-1 -: COUNTER_BITS];
    assign n_sync_cnt = COUNTER_BITS'(32'(i_item.counter_now));
    assign w_capture  = i_item.mode && (i_item.captured_word != '0);

    // Load the snapshot on a sync item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_secs <= '0;
            r_sync_sub  <= '0;
            r_sync_cnt  <= '0;
        end else if (w_accept && !i_item.mode) begin
            r_sync_secs <= i_item.clock_seconds;
            r_sync_sub  <= i_item.clock_subseconds;
            r_sync_cnt  <= n_sync_cnt;
        end
    end

    // Register offset back to the snapshot, wrapping modulo the counter range
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_en) begin
            r_valid <= w_accept && w_capture;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_offset    <= r_sync_cnt - w_cnt;
            r_snap.secs <= r_sync_secs;
            r_snap.sub  <= r_sync_sub;
        end
    end

    assign o_valid  = r_valid;
    assign o_offset = r_offset;
    assign o_snap   = r_snap;

endmodule

`default_nettype wire

>>> hdl/ctc_scale.sv
// Scaling section: tick offset to microseconds, too-old check and
// microseconds to subseconds, two register stages. Depends on ctc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ctc_scale
    import ctc_pkg::*;
#(
    parameter int COUNTER_BITS = CTC_COUNTER_BITS
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    output logic                         o_ready,
    input  wire logic [COUNTER_BITS-1:0] i_offset,
    input  wire t_snap                   i_snap,
    output logic                         o_valid,
    input  wire logic                    i_ready,
    output t_scaled                      o_scaled
);

    localparam int PROD_BITS = COUNTER_BITS + CTC_TICK_SHIFT;

    logic                     r_a_valid;
    logic [COUNTER_BITS-1:0]  r_a_us;
    t_snap                    r_a_snap;

    logic                     r_b_valid;
    t_scaled                  r_b;

    logic                     w_a_en;
    logic                     w_b_en;
    logic [PROD_BITS-1:0]     w_prod;
    logic [31:0]              w_us_ext;

    assign w_b_en  = !r_b_valid || i_ready;
    assign w_a_en  = !r_a_valid || w_b_en;
    assign o_ready = w_a_en;

    // Multiply by the fixed-point tick period and drop the fraction
    assign w_prod = PROD_BITS'(i_offset) * PROD_BITS'(CTC_TICK_MUL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_a_en) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_a_en) begin
            r_a_us   <= w_prod[PROD_BITS-1:CTC_TICK_SHIFT];
            r_a_snap <= i_snap;
        end
    end

    // Flag offsets of a second or more; scale the rest to subseconds
    assign w_us_ext = 32'(r_a_us);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (w_b_en) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_b_en) begin
            r_b.too_old <= (w_us_ext >= CTC_US_PER_SEC);
            r_b.subsec  <= CTC_SUB_BITS'(w_us_ext[CTC_US_LOW_BITS-1:0])
                         * CTC_SUB_BITS'(CTC_SUBSEC_PER_US);
            r_b.snap    <= r_a_snap;
        end
    end

    assign o_valid  = r_b_valid;
    assign o_scaled = r_b;

endmodule

`default_nettype wire

>>> hdl/ctc_tail.sv
// Tail section: borrow subtract from the snapshot, divide subseconds by 75
// and drive the result channel. Depends on ctc_pkg and ctc_out_if.
`timescale 1ns / 1ps
`default_nettype none

module ctc_tail
    import ctc_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    output logic         o_ready,
    input  wire t_scaled i_scaled,
    ctc_out_if.source    o_result
);

    logic                         r_c_valid;
    logic                         r_c_old;
    logic [CTC_SECS_BITS-1:0]     r_c_secs;
    logic [CTC_SUB_BITS-1:0]      r_c_sub;

    logic                         r_d_valid;
    logic                         r_d_old;
    logic [CTC_SECS_BITS-1:0]     r_d_secs;
    logic [CTC_DIV_PROD_BITS-1:0] r_d_prod;

    logic                         r_e_valid;
    logic                         r_e_old;
    logic [CTC_SECS_BITS-1:0]     r_e_secs;
    logic [CTC_US_BITS-1:0]       r_e_us;

    logic                         w_c_en;
    logic                         w_d_en;
    logic                         w_e_en;
    logic                         w_no_borrow;
    logic [CTC_SUB_BITS-1:0]      w_diff;
    logic [CTC_QUOT_BITS-1:0]     w_quot;

    assign w_e_en  = !r_e_valid || o_result.ready;
    assign w_d_en  = !r_d_valid || w_e_en;
    assign w_c_en  = !r_c_valid || w_d_en;
    assign o_ready = w_c_en;

    // Subtract from the snapshot, borrowing one second when short
    assign w_no_borrow = (i_scaled.snap.sub >= i_scaled.subsec);
    assign w_diff      = i_scaled.snap.sub - i_scaled.subsec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
            r_e_valid <= 1'b0;
        end else begin
            if (w_c_en) begin
                r_c_valid <= i_valid;
            end
            if (w_d_en) begin
                r_d_valid <= r_c_valid;
            end
            if (w_e_en) begin
                r_e_valid <= r_d_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_c_en) begin
            r_c_old <= i_scaled.too_old;
            if (w_no_borrow) begin
                r_c_secs <= i_scaled.snap.secs;
                r_c_sub  <= w_diff;
            end else begin
                r_c_secs <= i_scaled.snap.secs - CTC_SECS_BITS'(1);
                r_c_sub  <= w_diff + CTC_SUBSEC_PER_SEC;
            end
        end
    end

    // Reciprocal multiply for the divide by 75
    always_ff @(posedge i_clk) begin
        if (w_d_en) begin
            r_d_old  <= r_c_old;
            r_d_secs <= r_c_secs;
            r_d_prod <= CTC_DIV_PROD_BITS'(r_c_sub) * CTC_DIV_PROD_BITS'(CTC_DIV_MUL);
        end
    end

    // Hold the result; all ones when too old
    assign w_quot = r_d_prod[CTC_DIV_PROD_BITS-1:CTC_DIV_SHIFT];

    always_ff @(posedge i_clk) begin
        if (w_e_en) begin
            r_e_old <= r_d_old;
            if (r_d_old) begin
                r_e_secs <= CTC_ALL_ONES;
                r_e_us   <= CTC_ALL_ONES;
            end else begin
                r_e_secs <= r_d_secs;
                r_e_us   <= CTC_US_BITS'(w_quot);
            end
        end
    end

    assign o_result.valid              = r_e_valid;
    assign o_result.event_seconds      = r_e_secs;
    assign o_result.event_microseconds = r_e_us;
    assign o_result.too_old            = r_e_old;

endmodule

`default_nettype wire

>>> hdl/capture_timestamp_converter.sv
// Capture timestamp converter: six register stages, one item per cycle while the
// result side is ready. Each item passes the front, scaling and tail stages in order;
// sync items and empty capture words give no result and leave a bubble.
// Each stage advances whenever the one after it is empty or moving.
// Reset (synchronous, active low) clears the snapshot to zero and empties
// the pipeline. Depends on ctc_pkg, ctc_if, ctc_front, ctc_scale, ctc_tail.
`timescale 1ns / 1ps
`default_nettype none

module capture_timestamp_converter
    import ctc_pkg::*;
#(
    parameter int COUNTER_BITS = CTC_COUNTER_BITS
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ctc_in_if.sink     i_item,
    ctc_out_if.source  o_result
);

    logic                    w_f_valid;
    logic                    w_f_ready;
    logic [COUNTER_BITS-1:0] w_f_offset;
    t_snap                   w_f_snap;

    logic                    w_s_valid;
    logic                    w_s_ready;
    t_scaled                 w_s_scaled;

    // Snapshot and tick offset
    ctc_front #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .o_valid  (w_f_valid),
        .i_ready  (w_f_ready),
        .o_offset (w_f_offset),
        .o_snap   (w_f_snap)
    );

    // Offset to subseconds
    ctc_scale #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_scale (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_f_valid),
        .o_ready  (w_f_ready),
        .i_offset (w_f_offset),
        .i_snap   (w_f_snap),
        .o_valid  (w_s_valid),
        .i_ready  (w_s_ready),
        .o_scaled (w_s_scaled)
    );

    // Borrow subtract, divide and output
    ctc_tail u_tail (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_s_valid),
        .o_ready  (w_s_ready),
        .i_scaled (w_s_scaled),
        .o_result (o_result)
    );

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
// Self-checking bench for capture_timestamp_converter: drives sync and capture
// items, predicts each event time and compares it with the converter output.
// Depends on ctc_pkg, ctc_if and the converter RTL.
`timescale 1ns / 1ps

module tb;
    import ctc_pkg::*;

    localparam int CNT_BITS = CTC_COUNTER_BITS;
    localparam int LOW_BITS = CTC_WORD_BITS - CNT_BITS;

    localparam logic MODE_SYNC    = 1'b0;
    localparam logic MODE_CAPTURE = 1'b1;

    // Event time arithmetic, kept apart from the package
    localparam logic [63:0] US_MUL       = 64'd14316553;
    localparam int          US_SHIFT     = 24;
    localparam logic [63:0] SUB_PER_US   = 64'd75;
    localparam logic [63:0] SUB_PER_SEC  = 64'd75000000;
    localparam logic [31:0] TIME_INVALID = 32'hFFFF_FFFF;

    // Last offset that still converts; one tick more is too old
    localparam logic [CNT_BITS-1:0] OFFSET_LAST_OK = CNT_BITS'(1171875);

    typedef struct packed {
        logic                     mode;
        logic [CTC_SECS_BITS-1:0] secs;
        logic [CTC_SUB_BITS-1:0]  sub;
        logic [CTC_NOW_BITS-1:0]  now;
        logic [CTC_WORD_BITS-1:0] word;
    } t_stamp_item;

    typedef struct packed {
        logic [CTC_SECS_BITS-1:0] secs;
        logic [CTC_US_BITS-1:0]   usecs;
        logic                     too_old;
    } t_event_time;

    logic i_clk;
    logic i_rst_n;

    ctc_in_if  item_if ();
    ctc_out_if result_if ();

    capture_timestamp_converter dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_if),
        .o_result (result_if)
    );

    // Predictor copy of the clock snapshot
    logic [CTC_SECS_BITS-1:0] snap_secs;
    logic [CTC_SUB_BITS-1:0]  snap_sub;
    logic [CNT_BITS-1:0]      snap_cnt;

    t_event_time         pending_events[$];
    int                  n_errors;
    bit                  full_rate;
    logic [CNT_BITS-1:0] sent_now;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Safety net against a hung handshake
    initial begin
        #5_000_000;
        $display("%0t: run timed out", $time);
        $display("Regression FAIL");
        $finish;
    end

    // Update the snapshot or work out the event time of one accepted item
    function automatic bit predict_event(input t_stamp_item it, output t_event_time ev);
        logic [CNT_BITS-1:0] cnt;
        logic [CNT_BITS-1:0] offset;
        logic [63:0]         usecs;
        logic [63:0]         subsec;
        logic [63:0]         left;
        logic [31:0]         secs;
        ev = '0;
        if (it.mode == MODE_SYNC) begin
            snap_secs = it.secs;
            snap_sub  = it.sub;
            snap_cnt  = it.now[CNT_BITS-1:0];
            return 1'b0;
        end
        if (it.word == '0)
            return 1'b0;
        cnt    = it.word[CTC_WORD_BITS-1 -: CNT_BITS];
        offset = snap_cnt - cnt;
        usecs  = (64'(offset) * US_MUL) >> US_SHIFT;
        subsec = usecs * SUB_PER_US;
        if (subsec >= SUB_PER_SEC) begin
            ev.secs    = TIME_INVALID;
            ev.usecs   = TIME_INVALID;
            ev.too_old = 1'b1;
            return 1'b1;
        end
        secs = snap_secs;
        if (64'(snap_sub) >= subsec) begin
            left = 64'(snap_sub) - subsec;
        end else begin
            secs = snap_secs - 32'd1;
            left = 64'(snap_sub) + SUB_PER_SEC - subsec;
        end
        ev.secs    = secs;
        ev.usecs   = 32'(left / SUB_PER_US);
        ev.too_old = 1'b0;
        return 1'b1;
    endfunction

    // Predict accepted items, then check accepted results in order
    always @(posedge i_clk) begin : track_events
        t_stamp_item it;
        t_event_time ev_exp;
        t_event_time ev_got;
        if (!i_rst_n) begin
            snap_secs = '0;
            snap_sub  = '0;
            snap_cnt  = '0;
            pending_events.delete();
        end else begin
            if (item_if.valid && item_if.ready) begin
                it.mode = item_if.mode;
                it.secs = item_if.clock_seconds;
                it.sub  = item_if.clock_subseconds;
                it.now  = item_if.counter_now;
                it.word = item_if.captured_word;
                if (predict_event(it, ev_exp))
                    pending_events.push_back(ev_exp);
            end
            if (result_if.valid && result_if.ready) begin
                ev_got.secs    = result_if.event_seconds;
                ev_got.usecs   = result_if.event_microseconds;
                ev_got.too_old = result_if.too_old;
                if (pending_events.size() == 0) begin
                    n_errors++;
                    $display("%0t: unexpected result secs=%h usecs=%h too_old=%b",
                             $time, ev_got.secs, ev_got.usecs, ev_got.too_old);
                end else begin
                    ev_exp = pending_events.pop_front();
                    if (ev_got.secs !== ev_exp.secs) begin
                        n_errors++;
                        $display("%0t: event_seconds expected %h actual %h",
                                 $time, ev_exp.secs, ev_got.secs);
                    end
                    if (ev_got.usecs !== ev_exp.usecs) begin
                        n_errors++;
                        $display("%0t: event_microseconds expected %h actual %h",
                                 $time, ev_exp.usecs, ev_got.usecs);
                    end
                    if (ev_got.too_old !== ev_exp.too_old) begin
                        n_errors++;
                        $display("%0t: too_old expected %b actual %b",
                                 $time, ev_exp.too_old, ev_got.too_old);
                    end
                end
            end
        end
    end

    // Stall the result side in bursts, with calm stretches between
    initial begin
        int hold;
        int cyc;
        hold = 0;
        cyc  = 0;
        result_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (full_rate) begin
                result_if.ready <= 1'b1;
            end else if (hold > 0) begin
                hold--;
                result_if.ready <= 1'b0;
            end else if ((cyc / 300) % 3 != 2 && $urandom_range(0, 9) == 0) begin
                hold = $urandom_range(1, 16) - 1;
                result_if.ready <= 1'b0;
            end else begin
                result_if.ready <= 1'b1;
            end
        end
    end

    // Send one item; valid stays high on return so the next item can follow
    task automatic send_item(input t_stamp_item it, input bit allow_gap);
        int gap;
        gap = 0;
        if (allow_gap && $urandom_range(0, 7) == 0)
            gap = $urandom_range(1, 16);
        if (gap != 0) begin
            item_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_if.valid            <= 1'b1;
        item_if.mode             <= it.mode;
        item_if.clock_seconds    <= it.secs;
        item_if.clock_subseconds <= it.sub;
        item_if.counter_now      <= it.now;
        item_if.captured_word    <= it.word;
        @(posedge i_clk);
        while (!item_if.ready) @(posedge i_clk);
    endtask

    // Sync snapshot; the capture word is junk and must be ignored
    task automatic send_sync(input logic [31:0] secs, input logic [26:0] sub,
                             input logic [24:0] now, input bit allow_gap);
        t_stamp_item it;
        it.mode  = MODE_SYNC;
        it.secs  = secs;
        it.sub   = sub;
        it.now   = now;
        it.word  = $urandom;
        sent_now = now[CNT_BITS-1:0];
        send_item(it, allow_gap);
    endtask

    // Capture word; the clock fields are junk and must be ignored
    task automatic send_capture(input logic [31:0] word, input bit allow_gap);
        t_stamp_item it;
        it.mode = MODE_CAPTURE;
        it.secs = $urandom;
        it.sub  = CTC_SUB_BITS'($urandom);
        it.now  = CTC_NOW_BITS'($urandom);
        it.word = word;
        send_item(it, allow_gap);
    endtask

    // Capture taken a given number of ticks before the last snapshot
    task automatic capture_at(input logic [CNT_BITS-1:0] offset, input bit allow_gap);
        logic [CNT_BITS-1:0] cnt;
        cnt = sent_now - offset;
        send_capture({cnt, LOW_BITS'($urandom)}, allow_gap);
    endtask

    task automatic test_directed_cases();
        // Zero snapshot: empty slot, offset zero, borrow below second zero
        send_sync(32'd0, 27'd0, 25'd0, 1'b1);
        send_capture(32'd0, 1'b1);
        send_capture(32'h0000_0001, 1'b1);
        capture_at(25'd2, 1'b1);
        capture_at(25'd1, 1'b1);
        send_capture(32'hFFFF_FFFF, 1'b1);
        // All fields at their top, around the too-old boundary
        send_sync(32'hFFFF_FFFF, 27'd74999999, 25'h1FF_FFFF, 1'b1);
        send_capture({25'h1FF_FFFF, 7'h7F}, 1'b1);
        capture_at(OFFSET_LAST_OK - 25'd1, 1'b1);
        capture_at(OFFSET_LAST_OK, 1'b1);
        capture_at(OFFSET_LAST_OK + 25'd1, 1'b1);
        capture_at(OFFSET_LAST_OK + 25'd2, 1'b1);
        capture_at(25'h1FF_FFFF, 1'b1);
        // Subtraction exactly to zero, then a borrow
        send_sync(32'd12345, 27'd75, 25'd5, 1'b1);
        capture_at(25'd2, 1'b1);
        capture_at(25'd4, 1'b1);
        // Snapshot subseconds past one second are used as given
        send_sync($urandom, 27'h7FF_FFFF, 25'($urandom), 1'b1);
        capture_at(25'd0, 1'b1);
        capture_at(OFFSET_LAST_OK, 1'b1);
        // Counter wrap between capture and snapshot
        send_sync(32'h8000_0000, 27'd37500000, 25'd10, 1'b1);
        send_capture({25'h1FF_FFFB, 7'h00}, 1'b1);
        send_capture({25'd10, 7'h40}, 1'b1);
    endtask

    // Random sync or capture; offset mostly valid, some near the edge or anywhere
    task automatic random_item(input bit allow_gap);
        int pick;
        int cls;
        logic [26:0] sub;
        pick = $urandom_range(0, 99);
        if (pick < 6) begin
            if ($urandom_range(0, 19) == 0)
                sub = 27'($urandom);
            else
                sub = 27'($urandom_range(0, 74999999));
            send_sync($urandom, sub, 25'($urandom), allow_gap);
        end else if (pick < 12) begin
            send_capture(32'd0, allow_gap);
        end else begin
            cls = $urandom_range(0, 99);
            if (cls < 30)
                capture_at(CNT_BITS'($urandom_range(0, 64)), allow_gap);
            else if (cls < 70)
                capture_at(CNT_BITS'($urandom_range(0, OFFSET_LAST_OK)), allow_gap);
            else if (cls < 85)
                capture_at(CNT_BITS'($urandom_range(OFFSET_LAST_OK - 3000,
                                                    OFFSET_LAST_OK + 3000)),
                           allow_gap);
            else
                capture_at(CNT_BITS'($urandom), allow_gap);
        end
    endtask

    task automatic test_random_traffic(input int n_items);
        for (int i = 0; i < n_items; i++)
            random_item((i / 100) % 3 != 2);
    endtask

    // Back-to-back items with the result side always ready
    task automatic test_full_rate(input int n_items);
        full_rate = 1'b1;
        for (int i = 0; i < n_items; i++)
            random_item(1'b0);
    endtask

    initial begin
        n_errors  = 0;
        full_rate = 1'b0;
        sent_now  = '0;
        i_rst_n                  <= 1'b0;
        item_if.valid            <= 1'b0;
        item_if.mode             <= MODE_SYNC;
        item_if.clock_seconds    <= '0;
        item_if.clock_subseconds <= '0;
        item_if.counter_now      <= '0;
        item_if.captured_word    <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_cases();
        test_random_traffic(1300);
        test_full_rate(200);
        item_if.valid <= 1'b0;

        // Drain, then give the pipeline time to show any stray result
        while (pending_events.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (n_errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
